@@ hdl/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Shader source flag scanner package
// Shared types, result kinds and character constants for the scanner blocks.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Default block size; input and output positions wrap at this count.
  localparam int unsigned SFS_MAX_BLOCK_BYTES = 65536;

  // Result kinds.
  localparam logic [1:0] SFS_KIND_CODE    = 2'd0;
  localparam logic [1:0] SFS_KIND_INCLUDE = 2'd1;
  localparam logic [1:0] SFS_KIND_DONE    = 2'd2;
  localparam logic [1:0] SFS_KIND_ERROR   = 2'd3;

  // Characters the scanner looks for.
  localparam logic [7:0] SFS_CH_DIGIT0     = 8'd48;
  localparam logic [7:0] SFS_CH_DIGIT9     = 8'd57;
  localparam logic [7:0] SFS_CH_LF         = 8'd10;
  localparam logic [7:0] SFS_CH_CR         = 8'd13;
  localparam logic [7:0] SFS_CH_TAB        = 8'd9;
  localparam logic [7:0] SFS_CH_SPACE      = 8'h20;
  localparam logic [7:0] SFS_CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] SFS_CH_UPPER_F    = 8'h46;
  localparam logic [7:0] SFS_CH_QUOTE      = 8'h22;
  localparam logic [7:0] SFS_CH_SLASH      = 8'h2F;
  localparam logic [7:0] SFS_CH_STAR       = 8'h2A;

  // The include keyword; its first character sits in the top byte.
  localparam logic [63:0] SFS_INC_WORD = "#include";

  // Lookahead window: element 0 is the oldest held byte.
  typedef logic [7:0][7:0] sfs_win_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  code_byte;
    logic [15:0] out_offset;
    logic [15:0] name_start;
    logic [15:0] name_length;
    logic [31:0] flag_mask;
    logic        final_result;
  } sfs_result_t;

  // Pattern decode of the window head, handed from the matcher to the engine.
  typedef struct packed {
    logic       line_cmt;
    logic       block_cmt;
    logic       include_hit;
    logic       flag_hit;
    logic       flag_valid;
    logic [4:0] flag_idx;
    logic       is_newline;
    logic       is_space;
    logic       is_quote;
  } sfs_match_t;

endpackage

@@ hdl/sfs_match.sv @@
// ----------------------------------------------------------------------------
// Shader source flag scanner window matcher
// Decodes comment marks, the include keyword and flag words at the window head.
// ----------------------------------------------------------------------------
module sfs_match (
  input  sfs_pkg::sfs_win_t   win,
  input  logic [3:0]          wcnt,
  input  logic                line_cmt,
  input  logic                block_cmt,
  output sfs_pkg::sfs_match_t m
);

  logic       rem2;
  logic       rem5;
  logic       rem8;
  logic       open_line;
  logic       open_block;
  logic       lc1;
  logic       bc1;
  logic       lc2;
  logic       bc2;
  logic       nl;
  logic       in_code;
  logic       inc_eq;
  logic       dig2;
  logic       dig3;
  logic [7:0] diff2;
  logic [7:0] diff3;
  logic [6:0] num;
  logic [6:0] num_m1;

  // Comment tracking as seen by the head byte.
  always_comb begin
    rem2       = (wcnt >= 4'd2);
    rem5       = (wcnt >= 4'd5);
    rem8       = (wcnt >= 4'd8);
    nl         = (win[0] == sfs_pkg::SFS_CH_LF) || (win[0] == sfs_pkg::SFS_CH_CR);
    open_line  = rem2 && !line_cmt && !block_cmt &&
                 (win[0] == sfs_pkg::SFS_CH_SLASH) && (win[1] == sfs_pkg::SFS_CH_SLASH);
    open_block = rem2 && !line_cmt && !block_cmt && !open_line &&
                 (win[0] == sfs_pkg::SFS_CH_SLASH) && (win[1] == sfs_pkg::SFS_CH_STAR);
    lc1 = line_cmt || open_line;
    bc1 = block_cmt || open_block;
    lc2 = lc1;
    bc2 = bc1;
    if (lc1 && nl) begin
      lc2 = 1'b0;
    end else if (bc1 && rem2 && (win[0] == sfs_pkg::SFS_CH_STAR) &&
                 (win[1] == sfs_pkg::SFS_CH_SLASH)) begin
      bc2 = 1'b0;
    end
    in_code = !lc2 && !bc2;
  end

  // Include keyword compare over all eight held bytes.
  always_comb begin
    inc_eq = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (win[i] != sfs_pkg::SFS_INC_WORD[63 - 8 * i -: 8]) begin
        inc_eq = 1'b0;
      end
    end
  end

  // Flag word number from the two decimal digits.
  always_comb begin
    dig2   = (win[2] >= sfs_pkg::SFS_CH_DIGIT0) && (win[2] <= sfs_pkg::SFS_CH_DIGIT9);
    dig3   = (win[3] >= sfs_pkg::SFS_CH_DIGIT0) && (win[3] <= sfs_pkg::SFS_CH_DIGIT9);
    diff2  = win[2] - sfs_pkg::SFS_CH_DIGIT0;
    diff3  = win[3] - sfs_pkg::SFS_CH_DIGIT0;
    num    = ({3'b000, diff2[3:0]} * 7'd10) + {3'b000, diff3[3:0]};
    num_m1 = num - 7'd1;
  end

  assign m.line_cmt    = lc2;
  assign m.block_cmt   = bc2;
  assign m.include_hit = in_code && rem8 && inc_eq;
  assign m.flag_hit    = in_code && rem5 && dig2 && dig3 &&
                         (win[0] == sfs_pkg::SFS_CH_UNDERSCORE) &&
                         (win[1] == sfs_pkg::SFS_CH_UPPER_F) &&
                         (win[4] == sfs_pkg::SFS_CH_UNDERSCORE);
  assign m.flag_valid  = (num >= 7'd1) && (num <= 7'd32);
  assign m.flag_idx    = num_m1[4:0];
  assign m.is_newline  = nl;
  assign m.is_space    = nl || (win[0] == sfs_pkg::SFS_CH_SPACE) ||
                         (win[0] == sfs_pkg::SFS_CH_TAB);
  assign m.is_quote    = (win[0] == sfs_pkg::SFS_CH_QUOTE);

endmodule

@@ hdl/sfs_engine.sv @@
// ----------------------------------------------------------------------------
// Shader source flag scanner engine
// Holds the lookahead window and scan state; one scan step a cycle while the buffer has room.
// ----------------------------------------------------------------------------
module sfs_engine #(
  parameter int unsigned MAX_BLOCK_BYTES = sfs_pkg::SFS_MAX_BLOCK_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 room,
  output logic                 in_ready,
  output logic                 push,
  output logic                 busy,
  output sfs_pkg::sfs_result_t res
);

  localparam int unsigned POS_W = $clog2(MAX_BLOCK_BYTES);
  localparam logic [POS_W:0] POS_LIMIT = (POS_W + 1)'(MAX_BLOCK_BYTES);
  localparam logic [3:0] WIN_FULL = 4'd8;

  // Scan modes; the last two split multi-result steps into one result a cycle.
  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_INCLUDE  = 3'd1;
  localparam logic [2:0] MODE_FLAGSKIP = 3'd2;
  localparam logic [2:0] MODE_FAILED   = 3'd3;
  localparam logic [2:0] MODE_FLAGEMIT = 3'd4;
  localparam logic [2:0] MODE_INCNL    = 3'd5;

  // Position advance with wrap at the block size.
  function automatic logic [POS_W-1:0] pos_inc1(input logic [POS_W-1:0] p);
    logic [POS_W:0] s;
    s = {1'b0, p} + (POS_W + 1)'(1);
    return (s >= POS_LIMIT) ? '0 : s[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_add8(input logic [POS_W-1:0] p);
    logic [POS_W:0] s;
    s = {1'b0, p} + (POS_W + 1)'(8);
    if (s >= POS_LIMIT) begin
      s = s - POS_LIMIT;
    end
    return s[POS_W-1:0];
  endfunction

  // True when the current state has another scan step to take.
  function automatic logic can_step(input logic [2:0] mode, input logic [3:0] cnt,
                                    input logic last);
    logic r;
    unique case (mode)
      MODE_NORMAL:   r = (cnt == WIN_FULL) || (last && (cnt != 4'd0));
      MODE_INCLUDE:  r = (cnt != 4'd0);
      MODE_FLAGSKIP: r = (cnt != 4'd0);
      MODE_FLAGEMIT: r = 1'b1;
      MODE_INCNL:    r = 1'b1;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  sfs_pkg::sfs_win_t    win_r, win_op, win_nxt;
  logic [3:0]           wcnt_r, wcnt_op, wcnt_nxt;
  logic                 lc_r, lc_op;
  logic                 bc_r, bc_op;
  logic [2:0]           mode_r, mode_op;
  logic                 qf_vld_r, qf_vld_op;
  logic [15:0]          qf_r, qf_op;
  logic                 ql_vld_r, ql_vld_op;
  logic [15:0]          ql_r, ql_op;
  logic [31:0]          flags_r, flags_op;
  logic [POS_W-1:0]     ipos_r, ipos_op;
  logic [POS_W-1:0]     ocnt_r, ocnt_op;
  logic [2:0]           fcnt_r, fcnt_op;
  logic                 busy_r, busy_nxt;
  logic                 fin_r, fin_op, fin_nxt;
  logic                 last_r, last_nxt;
  logic                 step;
  logic                 emit_code;
  logic                 cons1;
  logic                 cons8;
  logic                 do_clear;
  logic                 push_op;
  logic                 ends_op;
  logic                 go;
  sfs_pkg::sfs_result_t res_op;
  sfs_pkg::sfs_match_t  m;

  sfs_match u_match (
    .win       (win_r),
    .wcnt      (wcnt_r),
    .line_cmt  (lc_r),
    .block_cmt (bc_r),
    .m         (m)
  );

  // One scan step, or one end-of-block step, on the registered state.
  always_comb begin
    win_op    = win_r;
    wcnt_op   = wcnt_r;
    lc_op     = lc_r;
    bc_op     = bc_r;
    mode_op   = mode_r;
    qf_vld_op = qf_vld_r;
    qf_op     = qf_r;
    ql_vld_op = ql_vld_r;
    ql_op     = ql_r;
    flags_op  = flags_r;
    ipos_op   = ipos_r;
    ocnt_op   = ocnt_r;
    fcnt_op   = fcnt_r;
    fin_op    = fin_r;
    emit_code = 1'b0;
    cons1     = 1'b0;
    cons8     = 1'b0;
    do_clear  = 1'b0;
    push_op   = 1'b0;
    ends_op   = 1'b0;
    res_op    = '0;
    step      = busy_r && room;

    if (step) begin
      if (fin_r) begin
        // Block end: close an open include line, then report done, unless in error.
        unique case (mode_r)
          MODE_FAILED: begin
            do_clear = 1'b1;
            ends_op  = 1'b1;
          end
          MODE_INCLUDE: begin
            push_op           = 1'b1;
            res_op.out_offset = 16'(ocnt_r);
            if (qf_vld_r && ql_vld_r) begin
              res_op.kind        = sfs_pkg::SFS_KIND_INCLUDE;
              res_op.name_start  = qf_r + 16'd1;
              res_op.name_length = ql_r - qf_r - 16'd1;
              mode_op            = MODE_NORMAL;
              qf_vld_op          = 1'b0;
              ql_vld_op          = 1'b0;
            end else begin
              res_op.kind         = sfs_pkg::SFS_KIND_ERROR;
              res_op.final_result = 1'b1;
              do_clear            = 1'b1;
              ends_op             = 1'b1;
            end
          end
          default: begin
            push_op             = 1'b1;
            res_op.kind         = sfs_pkg::SFS_KIND_DONE;
            res_op.out_offset   = 16'(ocnt_r);
            res_op.flag_mask    = flags_r;
            res_op.final_result = 1'b1;
            do_clear            = 1'b1;
            ends_op             = 1'b1;
          end
        endcase
      end else begin
        unique case (mode_r)
          MODE_NORMAL: begin
            lc_op = m.line_cmt;
            bc_op = m.block_cmt;
            if (m.include_hit) begin
              cons8     = 1'b1;
              mode_op   = MODE_INCLUDE;
              qf_vld_op = 1'b0;
              ql_vld_op = 1'b0;
            end else if (m.flag_hit) begin
              if (m.flag_valid) begin
                flags_op[m.flag_idx] = 1'b1;
              end
              emit_code = 1'b1;
              cons1     = 1'b1;
              mode_op   = MODE_FLAGEMIT;
              fcnt_op   = 3'd4;
            end else begin
              emit_code = 1'b1;
              cons1     = 1'b1;
            end
          end
          MODE_INCLUDE: begin
            if (m.is_quote) begin
              if (!qf_vld_r) begin
                qf_vld_op = 1'b1;
                qf_op     = 16'(ipos_r);
              end else begin
                ql_vld_op = 1'b1;
                ql_op     = 16'(ipos_r);
              end
              cons1 = 1'b1;
            end else if (m.is_newline) begin
              push_op           = 1'b1;
              res_op.out_offset = 16'(ocnt_r);
              qf_vld_op         = 1'b0;
              ql_vld_op         = 1'b0;
              if (qf_vld_r && ql_vld_r) begin
                res_op.kind        = sfs_pkg::SFS_KIND_INCLUDE;
                res_op.name_start  = qf_r + 16'd1;
                res_op.name_length = ql_r - qf_r - 16'd1;
                mode_op            = MODE_INCNL;
              end else begin
                res_op.kind         = sfs_pkg::SFS_KIND_ERROR;
                res_op.final_result = 1'b1;
                mode_op             = MODE_FAILED;
                wcnt_op             = '0;
              end
            end else begin
              cons1 = 1'b1;
            end
          end
          MODE_FLAGSKIP: begin
            cons1 = 1'b1;
            if (m.is_space) begin
              emit_code = 1'b1;
              mode_op   = MODE_NORMAL;
            end
          end
          MODE_FLAGEMIT: begin
            emit_code = 1'b1;
            cons1     = 1'b1;
            fcnt_op   = fcnt_r - 3'd1;
            if (fcnt_r == 3'd1) begin
              mode_op = MODE_FLAGSKIP;
            end
          end
          MODE_INCNL: begin
            emit_code = 1'b1;
            cons1     = 1'b1;
            mode_op   = MODE_NORMAL;
          end
          default: begin
          end
        endcase
      end

      // Drop consumed bytes from the window head.
      if (cons1) begin
        for (int i = 0; i < 7; i++) begin
          win_op[i] = win_r[i + 1];
        end
        wcnt_op = wcnt_r - 4'd1;
        ipos_op = pos_inc1(ipos_r);
      end
      if (cons8) begin
        wcnt_op = '0;
        ipos_op = pos_add8(ipos_r);
      end

      // A passed code byte carries the running output count.
      if (emit_code) begin
        push_op           = 1'b1;
        res_op.kind       = sfs_pkg::SFS_KIND_CODE;
        res_op.code_byte  = win_r[0];
        res_op.out_offset = 16'(ocnt_r);
        ocnt_op           = pos_inc1(ocnt_r);
      end

      // Start the next block clean.
      if (do_clear) begin
        wcnt_op   = '0;
        lc_op     = 1'b0;
        bc_op     = 1'b0;
        mode_op   = MODE_NORMAL;
        qf_vld_op = 1'b0;
        ql_vld_op = 1'b0;
        flags_op  = '0;
        ipos_op   = '0;
        ocnt_op   = '0;
      end

      // When the scan runs dry, the request is finished or its block closes.
      if (!fin_r && !can_step(mode_op, wcnt_op, last_r)) begin
        if (last_r) begin
          fin_op = 1'b1;
        end else begin
          ends_op = 1'b1;
        end
      end
    end
  end

  // Append an accepted byte behind whatever this cycle's step left.
  always_comb begin
    win_nxt  = win_op;
    wcnt_nxt = wcnt_op;
    busy_nxt = busy_r;
    fin_nxt  = fin_op;
    last_nxt = last_r;
    go       = 1'b0;
    if (ends_op) begin
      busy_nxt = 1'b0;
      fin_nxt  = 1'b0;
    end
    if (in_fire) begin
      if ((mode_op != MODE_FAILED) && (wcnt_op < WIN_FULL)) begin
        win_nxt[wcnt_op[2:0]] = in_byte;
        wcnt_nxt              = wcnt_op + 4'd1;
      end
      last_nxt = in_last;
      go       = can_step(mode_op, wcnt_nxt, in_last);
      busy_nxt = in_last || go;
      fin_nxt  = in_last && !go;
    end
  end

  // Window, quote positions and step counters.
  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    qf_r   <= qf_op;
    ql_r   <= ql_op;
    fcnt_r <= fcnt_op;
    last_r <= last_nxt;
  end

  // Control and scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r   <= '0;
      lc_r     <= 1'b0;
      bc_r     <= 1'b0;
      mode_r   <= MODE_NORMAL;
      qf_vld_r <= 1'b0;
      ql_vld_r <= 1'b0;
      flags_r  <= '0;
      ipos_r   <= '0;
      ocnt_r   <= '0;
      busy_r   <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      wcnt_r   <= wcnt_nxt;
      lc_r     <= lc_op;
      bc_r     <= bc_op;
      mode_r   <= mode_op;
      qf_vld_r <= qf_vld_op;
      ql_vld_r <= ql_vld_op;
      flags_r  <= flags_op;
      ipos_r   <= ipos_op;
      ocnt_r   <= ocnt_op;
      busy_r   <= busy_nxt;
      fin_r    <= fin_nxt;
    end
  end

  assign in_ready = !busy_r || ends_op;
  assign push     = push_op;
  assign res      = res_op;
  assign busy     = busy_r;

endmodule

@@ hdl/sfs_outbuf.sv @@
// ----------------------------------------------------------------------------
// Shader source flag scanner result buffer
// Two-entry result queue that decouples the scan engine from output stalls.
// ----------------------------------------------------------------------------
module sfs_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfs_pkg::sfs_result_t push_data,
  input  logic                 pop,
  output logic                 room,
  output logic                 valid,
  output sfs_pkg::sfs_result_t head
);

  sfs_pkg::sfs_result_t ent_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign room  = (cnt_r != 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rd_ptr_r];

endmodule

@@ hdl/shader_source_flag_scanner_core.sv @@
// ----------------------------------------------------------------------------
// Shader source flag scanner
// Streams shader source bytes, strips include lines and flag-word tails, and
// reports include locations and the flag mask of each source block.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one source byte and a last flag that closes a block.
//   Result requests carry a kind: passed code byte, include found, done with
//   the flag mask, or include syntax error. Done and error carry final_result.
//   The engine holds up to eight bytes of lookahead, so code bytes come out
//   seven bytes behind the input; the first result of a request passes the
//   engine state register and the result buffer before it is offered.
//   Throughput is one byte per cycle while each byte yields at most one
//   result and the buffer has room. The engine produces one result per cycle
//   while the buffer has room; a request that yields several results holds it
//   until all are out (a flag word gives five in a row), and a last byte drains
//   the held bytes, closes an include line still open and then reports done.
//   Results queue in a two-entry buffer, so input is taken while a result
//   waits; when the receiver stalls the buffer fills and in_ready drops.
//   Reset clears the scan state, the lookahead and the result buffer.
// ----------------------------------------------------------------------------
module shader_source_flag_scanner_core #(
  parameter int unsigned MAX_BLOCK_BYTES = sfs_pkg::SFS_MAX_BLOCK_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_code_byte,
  output logic [15:0] out_out_offset,
  output logic [15:0] out_name_start,
  output logic [15:0] out_name_length,
  output logic [31:0] out_flag_mask,
  output logic        out_final_result
);

  logic                 in_fire;
  logic                 out_pop;
  logic                 eng_push;
  logic                 eng_busy;
  logic                 buf_room;
  sfs_pkg::sfs_result_t eng_res;
  sfs_pkg::sfs_result_t head;

  assign in_fire = in_valid && in_ready;
  assign out_pop = out_valid && out_ready;

  // Scan engine.
  sfs_engine #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_data_byte),
    .in_last  (in_last_byte),
    .room     (buf_room),
    .in_ready (in_ready),
    .push     (eng_push),
    .busy     (eng_busy),
    .res      (eng_res)
  );

  // Result buffer toward the receiver.
  sfs_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (eng_push),
    .push_data (eng_res),
    .pop       (out_pop),
    .room      (buf_room),
    .valid     (out_valid),
    .head      (head)
  );

  assign out_kind         = head.kind;
  assign out_code_byte    = head.code_byte;
  assign out_out_offset   = head.out_offset;
  assign out_name_start   = head.name_start;
  assign out_name_length  = head.name_length;
  assign out_flag_mask    = head.flag_mask;
  assign out_final_result = head.final_result;

`ifndef SYNTH
  // The engine only produces a result when the buffer can take it.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    eng_push |-> buf_room)
    else $error("result pushed into a full buffer");

  // A done result closes the block and frees the engine.
  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (eng_push && (eng_res.kind == sfs_pkg::SFS_KIND_DONE) && !in_fire) |=> !eng_busy)
    else $error("engine still busy after done result");

  // Only done and error results end a block.
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (eng_push && eng_res.final_result) |->
      ((eng_res.kind == sfs_pkg::SFS_KIND_DONE) || (eng_res.kind == sfs_pkg::SFS_KIND_ERROR)))
    else $error("final flag on a non-final result");

  // Reset leaves no stale result on the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");
`endif

endmodule
